// ===== rtl/core/slcqb_pkg.sv =====
// shared types, codes and constants for the serial link command queue bridge
// no dependencies

package slcqb_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int BYTE_W      = 8;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [1:0] {
      OP_LINK = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_IN_FULL  = 3'd1,
      ST_BAD_CMD  = 3'd2,
      ST_HALTED   = 3'd3,
      ST_OUT_DROP = 3'd4
   } status_type;

   localparam byte_type CMD_ECHO      = 8'h01;
   localparam byte_type CMD_STATUS    = 8'h80;
   localparam byte_type CMD_READ      = 8'h81;
   localparam byte_type REPLY_PENDING = 8'h40;
   localparam byte_type REPLY_EMPTY   = 8'h00;

   // decided result of one request, waiting for the ram read data
   typedef struct packed {
      logic       reply_valid;
      byte_type   reply_first;
      byte_type   reply_second;
      logic       use_out_data;
      logic       host_valid;
      status_type status;
   } stage_type;

   function automatic ptr_type next_ptr(input ptr_type p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

// ===== rtl/core/slcqb_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies

module slcqb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/serial_link_command_queue_bridge.sv =====
// serial link command queue bridge: link commands and host access to two byte queues
// depends on slcqb_pkg and slcqb_ram
//
// requests enter on the req_ stream: req_tuser carries the operation (link command
// pair, host push of an outbound byte, host pop of an inbound byte), req_tdata the
// bytes. every request gives exactly one response on the rsp_ stream with the link
// reply, the popped host byte and a status code.
// a request is decided in the cycle it is accepted: queue pointers move and the
// queue ram is written or read at that edge. the ram read data is ready in the
// following cycle; the response register is loaded from the decided stage when it
// is empty or being taken, raising rsp_tvalid. one request per cycle is sustained
// with rsp_tready high; each ram read port and the response register set that figure.
// when rsp_tready is low the response holds, the decided stage behind it fills and
// then req_tready drops until the response is taken.
// reset empties both queues and clears the halt flag; queue contents are not cleared.
// an unknown command or a payload for a full inbound queue halts the block, and
// every later request answers with the halted status until reset.

module serial_link_command_queue_bridge
   import slcqb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // cmd_byte[7:0], arg_byte[15:8], host_byte[23:16]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // reply_first[7:0], reply_second[15:8], host_data[23:16]
   output logic [4:0]  rsp_tuser   // reply_valid[0], host_valid[1], status[4:2]
);

   ptr_type   in_head_ff, in_head_in, in_tail_ff, in_tail_in;
   ptr_type   out_head_ff, out_head_in, out_tail_ff, out_tail_in;
   logic      halted_ff, halted_in;
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_tdata_ff, rsp_tdata_in;
   logic [4:0]  rsp_tuser_ff, rsp_tuser_in;

   logic     req_accept, s1_move;
   op_type   op;
   byte_type cmd_byte, arg_byte, host_byte;
   logic     in_wr_en, out_wr_en, in_rd_en, out_rd_en;
   byte_type in_rd_data, out_rd_data;
   logic     in_empty, in_full, out_empty, out_full;

   assign op        = op_type'(req_tuser);
   assign cmd_byte  = req_tdata[7:0];
   assign arg_byte  = req_tdata[15:8];
   assign host_byte = req_tdata[23:16];

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   assign in_empty  = (in_head_ff == in_tail_ff);
   assign in_full   = (next_ptr(in_head_ff) == in_tail_ff);
   assign out_empty = (out_head_ff == out_tail_ff);
   assign out_full  = (next_ptr(out_head_ff) == out_tail_ff);

   // request decode and queue pointer update
   always_comb begin
      in_head_in  = in_head_ff;
      in_tail_in  = in_tail_ff;
      out_head_in = out_head_ff;
      out_tail_in = out_tail_ff;
      halted_in   = halted_ff;
      in_wr_en    = 1'b0;
      out_wr_en   = 1'b0;
      in_rd_en    = 1'b0;
      out_rd_en   = 1'b0;
      s1_in       = '0;
      s1_in.status = ST_OK;
      if (req_accept) begin
         if (halted_ff) begin
            s1_in.status = ST_HALTED;
         end else begin
            unique case (op)
               OP_LINK: begin
                  unique case (cmd_byte)
                     CMD_ECHO: begin
                        s1_in.reply_valid  = 1'b1;
                        s1_in.reply_first  = CMD_ECHO;
                        s1_in.reply_second = arg_byte;
                        if (in_full) begin
                           halted_in    = 1'b1;
                           s1_in.status = ST_IN_FULL;
                        end else begin
                           in_wr_en   = 1'b1;
                           in_head_in = next_ptr(in_head_ff);
                        end
                     end
                     CMD_STATUS: begin
                        s1_in.reply_valid  = 1'b1;
                        s1_in.reply_first  = CMD_STATUS;
                        s1_in.reply_second = out_empty ? REPLY_EMPTY : REPLY_PENDING;
                     end
                     CMD_READ: begin
                        s1_in.reply_valid  = 1'b1;
                        s1_in.reply_first  = CMD_READ;
                        s1_in.reply_second = REPLY_EMPTY;
                        if (!out_empty) begin
                           out_rd_en          = 1'b1;
                           s1_in.use_out_data = 1'b1;
                           out_tail_in        = next_ptr(out_tail_ff);
                        end
                     end
                     default: begin
                        halted_in    = 1'b1;
                        s1_in.status = ST_BAD_CMD;
                     end
                  endcase
               end
               OP_PUSH: begin
                  if (out_full) begin
                     s1_in.status = ST_OUT_DROP;
                  end else begin
                     out_wr_en   = 1'b1;
                     out_head_in = next_ptr(out_head_ff);
                  end
               end
               OP_POP: begin
                  if (!in_empty) begin
                     in_rd_en         = 1'b1;
                     s1_in.host_valid = 1'b1;
                     in_tail_in       = next_ptr(in_tail_ff);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // stage and response register control
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_tdata_in[7:0]   = s1_ff.reply_first;
         rsp_tdata_in[15:8]  = s1_ff.use_out_data ? out_rd_data : s1_ff.reply_second;
         rsp_tdata_in[23:16] = s1_ff.host_valid ? in_rd_data : REPLY_EMPTY;
         rsp_tuser_in = {s1_ff.status, s1_ff.host_valid, s1_ff.reply_valid};
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_head_ff   <= '0;
         in_tail_ff   <= '0;
         out_head_ff  <= '0;
         out_tail_ff  <= '0;
         halted_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_head_ff   <= in_head_in;
         in_tail_ff   <= in_tail_in;
         out_head_ff  <= out_head_in;
         out_tail_ff  <= out_tail_in;
         halted_ff    <= halted_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   slcqb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_inbound_ram (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_head_ff),
      .wr_data (arg_byte),
      .rd_en   (in_rd_en),
      .rd_addr (in_tail_ff),
      .rd_data (in_rd_data)
   );

   slcqb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_outbound_ram (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_head_ff),
      .wr_data (host_byte),
      .rd_en   (out_rd_en),
      .rd_addr (out_tail_ff),
      .rd_data (out_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   // a request taken while halted is answered with the halted status
   a_halted_status: assert property (@(posedge clock) disable iff (reset)
      (req_accept && halted_ff) |=> (s1_valid_ff && s1_ff.status == ST_HALTED))
      else $error("halted request not flagged");

   // halted or error responses carry no host byte
   a_no_host_on_error: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.status != ST_OK) |-> !s1_ff.host_valid)
      else $error("host byte with error status");

   // pointers never move while halted
   a_ptrs_frozen: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> ($stable(in_head_ff) && $stable(in_tail_ff)
                     && $stable(out_head_ff) && $stable(out_tail_ff)))
      else $error("queue pointer moved while halted");

   // a pending decided request is never overwritten
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |-> !req_tready)
      else $error("request accepted into a full stage");

endmodule

// ===== tb/testbench.sv =====
// self-checking bench for serial_link_command_queue_bridge: request driver, response monitor
// and a behavioral model of both byte queues and the halt flag
// depends on slcqb_pkg and the bridge rtl
`timescale 1ns / 100ps

module testbench;
   import slcqb_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int TOTAL_ITEMS  = 1250;
   localparam int TAIL_ITEMS   = 19;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LO     = 600;
   localparam int QUIET_HI     = 800;
   localparam int FULL_COUNT   = QUEUE_DEPTH - 1;

   typedef struct packed {
      op_type   op;
      byte_type cmd;
      byte_type arg;
      byte_type host;
   } req_item_type;

   typedef struct packed {
      logic       reply_valid;
      byte_type   reply_first;
      byte_type   reply_second;
      logic       host_valid;
      byte_type   host_data;
      status_type status;
   } bridge_reply_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [4:0]  rsp_tuser;

   req_item_type     request_q[$];
   bridge_reply_type reply_q[$];

   // model state
   byte_type in_mem  [QUEUE_DEPTH];
   byte_type out_mem [QUEUE_DEPTH];
   ptr_type  in_wr   = '0;
   ptr_type  in_rd   = '0;
   ptr_type  out_wr  = '0;
   ptr_type  out_rd  = '0;
   bit       halted  = 1'b0;

   // generator occupancy
   int gen_in  = 0;
   int gen_out = 0;

   int               err_count    = 0;
   int               req_count    = 0;
   int               rsp_count    = 0;
   int               rsp_seen     = 0;
   int               stall_cycles = 0;
   int               hold_left    = 0;
   bit               hold_done    = 1'b0;
   bit               halt_by_cmd  = 1'b0;
   req_item_type     cur_req;
   bridge_reply_type predicted;

   serial_link_command_queue_bridge i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic ptr_type step_ptr(input ptr_type v);
      return ptr_type'((int'(v) + 1) % QUEUE_DEPTH);
   endfunction

   task automatic apply_request(input req_item_type r, output bridge_reply_type p);
      p = '0;
      p.status = ST_OK;
      if (halted) begin
         p.status = ST_HALTED;
      end else begin
         case (r.op)
            OP_LINK: begin
               if (r.cmd == CMD_ECHO) begin
                  p.reply_valid  = 1'b1;
                  p.reply_first  = CMD_ECHO;
                  p.reply_second = r.arg;
                  if (step_ptr(in_wr) == in_rd) begin
                     halted   = 1'b1;
                     p.status = ST_IN_FULL;
                  end else begin
                     in_mem[in_wr] = r.arg;
                     in_wr         = step_ptr(in_wr);
                  end
               end else if (r.cmd == CMD_STATUS) begin
                  p.reply_valid  = 1'b1;
                  p.reply_first  = CMD_STATUS;
                  p.reply_second = (out_wr != out_rd) ? REPLY_PENDING : REPLY_EMPTY;
               end else if (r.cmd == CMD_READ) begin
                  p.reply_valid  = 1'b1;
                  p.reply_first  = CMD_READ;
                  p.reply_second = REPLY_EMPTY;
                  if (out_wr != out_rd) begin
                     p.reply_second = out_mem[out_rd];
                     out_rd         = step_ptr(out_rd);
                  end
               end else begin
                  halted   = 1'b1;
                  p.status = ST_BAD_CMD;
               end
            end
            OP_PUSH: begin
               if (step_ptr(out_wr) == out_rd) begin
                  p.status = ST_OUT_DROP;
               end else begin
                  out_mem[out_wr] = r.host;
                  out_wr          = step_ptr(out_wr);
               end
            end
            OP_POP: begin
               if (in_wr != in_rd) begin
                  p.host_valid = 1'b1;
                  p.host_data  = in_mem[in_rd];
                  in_rd        = step_ptr(in_rd);
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic add_req(input op_type op, input byte_type cmd, input byte_type arg,
                          input byte_type host);
      req_item_type r;
      r.op   = op;
      r.cmd  = cmd;
      r.arg  = arg;
      r.host = host;
      request_q.push_back(r);
      if (op == OP_LINK && cmd == CMD_ECHO && gen_in < FULL_COUNT) gen_in++;
      if (op == OP_LINK && cmd == CMD_READ && gen_out > 0) gen_out--;
      if (op == OP_PUSH && gen_out < FULL_COUNT) gen_out++;
      if (op == OP_POP && gen_in > 0) gen_in--;
   endtask

   function automatic byte_type rnd_byte();
      return byte_type'($urandom_range(0, 255));
   endfunction

   function automatic bit idle_now(input int count);
      if (count >= QUIET_LO && count < QUIET_HI) return 1'b0;
      return $urandom_range(0, 99) < 19;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      err_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(cur_req, predicted);
            reply_q.push_back(predicted);
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_q.size() != 0 && !idle_now(req_count)) begin
               cur_req = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_req.host, cur_req.arg, cur_req.cmd};
               req_tuser  <= cur_req.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_now(rsp_seen);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      bridge_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reply_q.size() == 0) begin
            report_mismatch($sformatf("response %0d with no request pending", rsp_count));
         end else begin
            want = reply_q.pop_front();
            if (rsp_tuser[0] !== want.reply_valid)
               report_mismatch($sformatf("response %0d reply_valid got %0h want %0h",
                               rsp_count, rsp_tuser[0], want.reply_valid));
            if (rsp_tdata[7:0] !== want.reply_first)
               report_mismatch($sformatf("response %0d reply_first got %0h want %0h",
                               rsp_count, rsp_tdata[7:0], want.reply_first));
            if (rsp_tdata[15:8] !== want.reply_second)
               report_mismatch($sformatf("response %0d reply_second got %0h want %0h",
                               rsp_count, rsp_tdata[15:8], want.reply_second));
            if (rsp_tuser[1] !== want.host_valid)
               report_mismatch($sformatf("response %0d host_valid got %0h want %0h",
                               rsp_count, rsp_tuser[1], want.host_valid));
            if (rsp_tdata[23:16] !== want.host_data)
               report_mismatch($sformatf("response %0d host_data got %0h want %0h",
                               rsp_count, rsp_tdata[23:16], want.host_data));
            if (rsp_tuser[4:2] !== want.status)
               report_mismatch($sformatf("response %0d status got %0h want %0h",
                               rsp_count, rsp_tuser[4:2], want.status));
         end
         rsp_count++;
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      int       phase_left;
      int       r;
      bit       in_fill;
      bit       out_fill;
      byte_type bad;

      phase_left = 0;
      in_fill    = 1'b0;
      out_fill   = 1'b0;

      // directed: empty queues, extremes, every command, unused op
      add_req(OP_POP,  8'hFF, 8'hFF, 8'hFF);
      add_req(OP_LINK, CMD_STATUS, 8'hFF, 8'hFF);
      add_req(OP_LINK, CMD_READ, 8'hFF, 8'h00);
      add_req(OP_PUSH, 8'h00, 8'h00, 8'h00);
      add_req(OP_PUSH, 8'hFF, 8'hFF, 8'hFF);
      add_req(OP_LINK, CMD_STATUS, 8'h00, 8'h00);
      add_req(OP_LINK, CMD_READ, 8'h00, 8'hFF);
      add_req(OP_LINK, CMD_READ, 8'hFF, 8'h00);
      add_req(OP_LINK, CMD_READ, 8'h00, 8'h00);
      add_req(OP_LINK, CMD_STATUS, 8'h00, 8'hFF);
      add_req(OP_LINK, CMD_ECHO, 8'h00, 8'hFF);
      add_req(OP_LINK, CMD_ECHO, 8'hFF, 8'h00);
      add_req(OP_LINK, CMD_ECHO, 8'h5A, 8'hA5);
      add_req(OP_POP,  8'h00, 8'h00, 8'h00);
      add_req(OP_POP,  8'h7E, 8'h81, 8'h18);
      add_req(OP_POP,  8'hFF, 8'h00, 8'hFF);
      add_req(OP_POP,  8'h00, 8'hFF, 8'h00);
      add_req(OP_NONE, 8'hFF, 8'hFF, 8'hFF);
      add_req(OP_NONE, 8'h00, 8'h00, 8'h00);
      add_req(OP_PUSH, 8'h7E, 8'h3C, 8'hA5);
      add_req(OP_LINK, CMD_READ, 8'hC3, 8'h00);

      // random traffic with drifting occupancy of both queues, leaving room for the
      // fill and halt sequences so the whole run stays near the item budget
      while (request_q.size() + (FULL_COUNT - gen_out) + (FULL_COUNT - gen_in)
             + TAIL_ITEMS < TOTAL_ITEMS) begin
         if (phase_left == 0) begin
            in_fill    = $urandom_range(0, 1);
            out_fill   = $urandom_range(0, 1);
            phase_left = $urandom_range(40, 160);
         end
         phase_left--;
         if (gen_in >= FULL_COUNT - 4) in_fill = 1'b0;
         r = $urandom_range(0, 95);
         if (r < (in_fill ? 30 : 12)) begin
            if (gen_in < FULL_COUNT)
               add_req(OP_LINK, CMD_ECHO, rnd_byte(), rnd_byte());
            else
               add_req(OP_POP, rnd_byte(), rnd_byte(), rnd_byte());
         end else if (r < 42) begin
            add_req(OP_POP, rnd_byte(), rnd_byte(), rnd_byte());
         end else if (r < 42 + (out_fill ? 30 : 12)) begin
            add_req(OP_PUSH, rnd_byte(), rnd_byte(), rnd_byte());
         end else if (r < 84) begin
            add_req(OP_LINK, CMD_READ, rnd_byte(), rnd_byte());
         end else if (r < 92) begin
            add_req(OP_LINK, CMD_STATUS, rnd_byte(), rnd_byte());
         end else begin
            add_req(OP_NONE, rnd_byte(), rnd_byte(), rnd_byte());
         end
      end

      // fill both queues to capacity, drops on the outbound side
      while (gen_out < FULL_COUNT) add_req(OP_PUSH, rnd_byte(), rnd_byte(), rnd_byte());
      repeat (3) add_req(OP_PUSH, rnd_byte(), rnd_byte(), rnd_byte());
      add_req(OP_LINK, CMD_STATUS, rnd_byte(), rnd_byte());
      while (gen_in < FULL_COUNT) add_req(OP_LINK, CMD_ECHO, rnd_byte(), rnd_byte());

      // halt, then requests that must all be refused
      halt_by_cmd = $urandom_range(0, 1);
      if (halt_by_cmd) begin
         do bad = rnd_byte();
         while (bad == CMD_ECHO || bad == CMD_STATUS || bad == CMD_READ);
         add_req(OP_LINK, bad, rnd_byte(), rnd_byte());
      end else begin
         add_req(OP_LINK, CMD_ECHO, rnd_byte(), rnd_byte());
      end
      repeat (12) add_req(op_type'($urandom_range(0, 3)), rnd_byte(), rnd_byte(), rnd_byte());
      add_req(OP_LINK, CMD_READ, rnd_byte(), rnd_byte());
      add_req(OP_POP, rnd_byte(), rnd_byte(), rnd_byte());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_tvalid) @(posedge clock);
      while (reply_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run: %0d requests, %0d responses; echo, status and read commands, host push",
               req_count, rsp_count);
      $display("run: and pop, both queues wrapped and filled, halt by %s, then refused requests",
               halt_by_cmd ? "unknown command" : "full inbound queue");
      if (err_count == 0 && reply_q.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/slcqb_pkg.sv
rtl/core/slcqb_ram.sv
rtl/core/serial_link_command_queue_bridge.sv
tb/testbench.sv
